// File: design/ger_pkg.sv
// Shared types, character codes and the OSC prefix table for the graphics
// escape recognizer. No dependencies; every other design file but ger_ram imports it.
package ger_pkg;

    localparam int PREFIX_MAX = 61;
    localparam int PFX_AW     = $clog2(PREFIX_MAX);
    localparam int LEN_W      = $clog2(PREFIX_MAX + 1);

    localparam int CAP_W = 24;
    localparam logic [CAP_W-1:0] CAP_RESET = 24'h10_0000;

    // Character codes
    localparam logic [7:0] CH_ESC  = 8'h1B;
    localparam logic [7:0] CH_CAN  = 8'h18;
    localparam logic [7:0] CH_SUB  = 8'h1A;
    localparam logic [7:0] CH_BEL  = 8'h07;
    localparam logic [7:0] CH_APC  = 8'h5F;  // '_'
    localparam logic [7:0] CH_OSC  = 8'h5D;  // ']'
    localparam logic [7:0] CH_DCS  = 8'h50;  // 'P'
    localparam logic [7:0] CH_G    = 8'h47;  // 'G'
    localparam logic [7:0] CH_Q    = 8'h71;  // 'q'
    localparam logic [7:0] CH_BSL  = 8'h5C;  // backslash
    localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;

    // Result kinds
    localparam logic [2:0] K_PASS  = 3'd0;
    localparam logic [2:0] K_PARAM = 3'd1;
    localparam logic [2:0] K_BODY  = 3'd2;
    localparam logic [2:0] K_DONE  = 3'd3;
    localparam logic [2:0] K_ABORT = 3'd4;

    // Sequence kinds; the OSC kinds are the pattern number plus one
    localparam logic [2:0] SEQ_APC = 3'd0;
    localparam logic [2:0] SEQ_DCS = 3'd5;

    // OSC file prefixes, right-aligned, zero-padded on the left
    localparam int OSC_N       = 4;
    localparam int OSC_TXT_MAX = 19;
    localparam logic [8*OSC_TXT_MAX-1:0] OSC_TXT [OSC_N] = '{
        "1337;File=",
        "1337;MultipartFile=",
        "1337;FilePart=",
        "1337;FileEnd"
    };
    localparam logic [4:0] OSC_LEN [OSC_N] = '{5'd10, 5'd19, 5'd14, 5'd12};

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [2:0] seq;
        logic       ovf;
    } result_t;

    typedef struct packed {
        logic    emit;
        logic    done;
        result_t res;
    } step_t;

    typedef struct packed {
        logic             full;
        logic             possible;
        logic [2:0]       kind;
        logic [OSC_N-1:0] mask;
    } osc_res_t;

    // Character at position idx of OSC prefix k; zero past its end
    function automatic logic [7:0] osc_char(input int k, input logic [LEN_W-1:0] idx);
        int pos;
        pos = int'(OSC_LEN[k]) - 1 - int'(idx);
        if (pos >= 0)
            return OSC_TXT[k][8*pos +: 8];
        return 8'h00;
    endfunction

endpackage

// File: design/ger_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module ger_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 61
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: design/ger_osc_match.sv
// OSC prefix matcher: checks the next byte against the four file prefixes.
// Depends on ger_pkg for the prefix table and the osc_res_t type.
module ger_osc_match import ger_pkg::*; (
    input  logic [OSC_N-1:0] mask,
    input  logic [LEN_W-1:0] len,
    input  logic [7:0]       c,
    output osc_res_t         res
);

    logic [OSC_N-1:0] hit;
    logic [OSC_N-1:0] full;

    // mask holds the prefixes that still agree with every byte held so far
    always_comb
    begin
        res = '0;
        for (int k = 0; k < OSC_N; k++)
        begin
            hit[k]  = mask[k] && (len < LEN_W'(OSC_LEN[k])) && (osc_char(k, len) == c);
            full[k] = hit[k] &&
                      (({1'b0, len} + 1'b1) == (LEN_W + 1)'(OSC_LEN[k]));
        end
        // lowest pattern number wins
        for (int k = OSC_N - 1; k >= 0; k--)
        begin
            if (full[k])
            begin
                res.kind = 3'(k + 1);
            end
        end
        res.full     = |full;
        res.mask     = hit & ~full;
        res.possible = |(hit & ~full);
    end

endmodule

// File: design/ger_out_stage.sv
// Result staging: one pending result (to learn which is last) and the output
// register. Depends on ger_pkg for result_t and step_t.
module ger_out_stage import ger_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  step_t   step,
    output logic    slot_free,
    output logic    hold,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t out_res,
    output logic    out_last
);

    logic    pend_valid_reg;
    logic    pend_valid_next;
    result_t pend_res_reg;
    result_t pend_res_next;
    logic    out_valid_reg;
    result_t out_res_reg;
    logic    out_last_reg;
    logic    push;
    result_t push_res;
    logic    push_last;

    always_comb
    begin
        slot_free       = !out_valid_reg || out_ready;
        hold            = step.emit && step.done && pend_valid_reg;
        push            = 1'b0;
        push_res        = pend_res_reg;
        push_last       = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_res_next   = pend_res_reg;
        if (fire)
        begin
            if (step.emit && !step.done)
            begin
                // more may follow: park the new result, release the older one
                push            = pend_valid_reg;
                pend_valid_next = 1'b1;
                pend_res_next   = step.res;
            end
            else if (step.emit && pend_valid_reg)
            begin
                // two to send: drain the pending one first, engine holds
                push            = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (step.emit)
            begin
                push      = 1'b1;
                push_res  = step.res;
                push_last = 1'b1;
            end
            else if (step.done && pend_valid_reg)
            begin
                push            = 1'b1;
                push_last       = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= push || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        pend_res_reg <= pend_res_next;
        if (push)
        begin
            out_res_reg  <= push_res;
            out_last_reg <= push_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_last  = out_last_reg;

endmodule

// File: design/graphics_escape_recognizer.sv
// Graphics escape recognizer top level: parse sequencer, prefix RAM, OSC
// matcher and result staging. Depends on ger_pkg, ger_ram, ger_osc_match, ger_out_stage.

// Filters a terminal byte stream: ordinary bytes come out as passthrough items,
// APC graphics (ESC _ G), OSC file (ESC ] 1337;...) and DCS raster (ESC P..q)
// introducers open a body whose bytes come out tagged with the sequence kind,
// capped at max_body_bytes (written through cfg_wr_en/cfg_wr_data; the user must
// write it only while the block is idle, the block does not enforce this), and a
// finish or abort item closes each body. Every result item leaves through an output
// register and last marks the final item that an input byte causes; a byte that
// causes none produces no item. An ordinary byte, body byte or introducer byte
// leaves the sequencer idle for the next byte while out_ready is high. The byte
// after a stray ESC is rescanned; if it passes through as well, the ESC and the
// byte leave one per cycle behind the pending result. A failed introducer replays
// the ESC, the introducer character and the held prefix bytes, an accepted DCS
// introducer its parameter bytes: the held bytes are replayed one per cycle from
// the prefix RAM (one read port, registered read data) through the single output
// register, which also sets the pace when the sink stalls. The prefix RAM is never
// cleared; only entries written in the current introducer are read back, and a
// write and a read of the same entry never share a cycle.
module graphics_escape_recognizer import ger_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [CAP_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       out_kind,
    output logic [7:0]       out_byte,
    output logic [2:0]       seq_kind,
    output logic             body_overflow,
    output logic             last
);

    // Sequencer states
    localparam logic [2:0] E_IDLE    = 3'd0;  // wait for an item, scan it at once
    localparam logic [2:0] E_SCAN    = 3'd1;  // rescan the held byte
    localparam logic [2:0] E_REP_ESC = 3'd2;  // replay the ESC
    localparam logic [2:0] E_REP_2ND = 3'd3;  // replay the introducer character
    localparam logic [2:0] E_STREAM  = 3'd4;  // stream held prefix bytes from RAM

    // Parser states
    localparam logic [2:0] P_GROUND   = 3'd0;
    localparam logic [2:0] P_ESC      = 3'd1;
    localparam logic [2:0] P_APC      = 3'd2;
    localparam logic [2:0] P_OSC      = 3'd3;
    localparam logic [2:0] P_DCS      = 3'd4;
    localparam logic [2:0] P_BODY     = 3'd5;
    localparam logic [2:0] P_BODY_ESC = 3'd6;

    logic [2:0]       eng_reg;
    logic [2:0]       eng_next;
    logic [2:0]       ps_reg;
    logic [2:0]       ps_next;
    logic [2:0]       seq_reg;
    logic [2:0]       seq_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] idx_reg;
    logic [LEN_W-1:0] idx_next;
    logic [OSC_N-1:0] mask_reg;
    logic [OSC_N-1:0] mask_next;
    logic [CAP_W-1:0] count_reg;
    logic [CAP_W-1:0] count_next;
    logic             ovf_reg;
    logic             ovf_next;
    logic             param_reg;
    logic             param_next;
    logic [7:0]       second_reg;
    logic [7:0]       second_next;
    logic [CAP_W-1:0] max_reg;
    logic [7:0]       c_reg;

    logic [7:0]        c;
    step_t             step;
    osc_res_t          osc;
    logic              fire;
    logic              advance;
    logic              slot_free;
    logic              hold;
    logic              wr_req;
    logic              rd_req;
    logic [PFX_AW-1:0] rd_addr;
    logic [7:0]        rd_data;
    logic              is_param;
    logic              osc_body;
    result_t           out_res;

    // The byte under scan: straight from the port when idle, else the held copy
    assign c        = (eng_reg == E_IDLE) ? in_byte : c_reg;
    assign is_param = ((c >= CH_0) && (c <= CH_9)) || (c == CH_SEMI);
    assign osc_body = (seq_reg != SEQ_APC) && (seq_reg != SEQ_DCS);

    assign in_ready = (eng_reg == E_IDLE) && slot_free;
    assign fire     = slot_free && ((eng_reg != E_IDLE) || in_valid);
    assign advance  = fire && !hold;

    ger_osc_match u_osc (
        .mask (mask_reg),
        .len  (len_reg),
        .c    (c),
        .res  (osc)
    );

    ger_ram #(
        .WIDTH (8),
        .DEPTH (PREFIX_MAX)
    ) u_prefix_ram (
        .clk     (clk),
        .wr_en   (advance && wr_req),
        .wr_addr (len_reg[PFX_AW-1:0]),
        .wr_data (c),
        .rd_en   (advance && rd_req),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ger_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .step      (step),
        .slot_free (slot_free),
        .hold      (hold),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_res   (out_res),
        .out_last  (last)
    );

    assign out_kind      = out_res.kind;
    assign out_byte      = out_res.data;
    assign seq_kind      = out_res.seq;
    assign body_overflow = out_res.ovf;

    // One step of the sequencer: at most one result per cycle
    always_comb
    begin
        eng_next    = eng_reg;
        ps_next     = ps_reg;
        seq_next    = seq_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        mask_next   = mask_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        param_next  = param_reg;
        second_next = second_reg;
        step        = '0;
        wr_req      = 1'b0;
        rd_req      = 1'b0;
        rd_addr     = '0;

        unique case (eng_reg)
            E_IDLE, E_SCAN:
            begin
                eng_next  = E_IDLE;
                step.done = 1'b1;
                unique case (ps_reg)
                    P_GROUND:
                    begin
                        if (c == CH_ESC)
                        begin
                            ps_next = P_ESC;
                        end
                        else
                        begin
                            step.emit = 1'b1;
                            step.res  = '{kind: K_PASS, data: c, seq: '0, ovf: 1'b0};
                        end
                    end
                    P_ESC:
                    begin
                        if (c == CH_APC)
                        begin
                            ps_next = P_APC;
                        end
                        else if (c == CH_OSC)
                        begin
                            len_next  = '0;
                            mask_next = '1;
                            ps_next   = P_OSC;
                        end
                        else if (c == CH_DCS)
                        begin
                            len_next = '0;
                            ps_next  = P_DCS;
                        end
                        else
                        begin
                            // lone ESC: pass it, then look at this byte again
                            step.emit = 1'b1;
                            step.done = 1'b0;
                            step.res  = '{kind: K_PASS, data: CH_ESC, seq: '0, ovf: 1'b0};
                            ps_next   = P_GROUND;
                            eng_next  = E_SCAN;
                        end
                    end
                    P_APC:
                    begin
                        if (c == CH_G)
                        begin
                            seq_next   = SEQ_APC;
                            count_next = '0;
                            ovf_next   = 1'b0;
                            ps_next    = P_BODY;
                        end
                        else
                        begin
                            step.done   = 1'b0;
                            len_next    = '0;
                            second_next = CH_APC;
                            eng_next    = E_REP_ESC;
                        end
                    end
                    P_OSC:
                    begin
                        if (osc.full)
                        begin
                            seq_next   = osc.kind;
                            count_next = '0;
                            ovf_next   = 1'b0;
                            ps_next    = P_BODY;
                        end
                        else if (osc.possible && (len_reg < LEN_W'(PREFIX_MAX)))
                        begin
                            wr_req    = 1'b1;
                            len_next  = len_reg + 1'b1;
                            mask_next = osc.mask;
                        end
                        else
                        begin
                            step.done   = 1'b0;
                            second_next = CH_OSC;
                            eng_next    = E_REP_ESC;
                        end
                    end
                    P_DCS:
                    begin
                        if (is_param && (len_reg < LEN_W'(PREFIX_MAX)))
                        begin
                            wr_req   = 1'b1;
                            len_next = len_reg + 1'b1;
                        end
                        else if (!is_param && (c == CH_Q))
                        begin
                            seq_next   = SEQ_DCS;
                            count_next = '0;
                            ovf_next   = 1'b0;
                            ps_next    = P_BODY;
                            if (len_reg != '0)
                            begin
                                // send the parameter bytes out of the RAM
                                step.done  = 1'b0;
                                rd_req     = 1'b1;
                                idx_next   = '0;
                                param_next = 1'b1;
                                eng_next   = E_STREAM;
                            end
                        end
                        else
                        begin
                            step.done   = 1'b0;
                            second_next = CH_DCS;
                            eng_next    = E_REP_ESC;
                        end
                    end
                    P_BODY:
                    begin
                        if (c == CH_ESC)
                        begin
                            ps_next = P_BODY_ESC;
                        end
                        else if ((c == CH_CAN) || (c == CH_SUB) ||
                                 (osc_body && (c == CH_BEL)))
                        begin
                            step.emit     = 1'b1;
                            step.res.kind = (c == CH_BEL) ? K_DONE : K_ABORT;
                            step.res.seq  = seq_reg;
                            step.res.ovf  = ovf_reg;
                            count_next    = '0;
                            ovf_next      = 1'b0;
                            ps_next       = P_GROUND;
                        end
                        else if (!ovf_reg)
                        begin
                            if (count_reg >= max_reg)
                            begin
                                // over the cap: drop this and every later body byte
                                ovf_next = 1'b1;
                            end
                            else
                            begin
                                count_next = count_reg + 1'b1;
                                step.emit  = 1'b1;
                                step.res   = '{kind: K_BODY, data: c, seq: seq_reg, ovf: 1'b0};
                            end
                        end
                    end
                    P_BODY_ESC:
                    begin
                        step.emit    = 1'b1;
                        step.res.seq = seq_reg;
                        step.res.ovf = ovf_reg;
                        count_next   = '0;
                        ovf_next     = 1'b0;
                        if (c == CH_BSL)
                        begin
                            step.res.kind = K_DONE;
                            ps_next       = P_GROUND;
                        end
                        else
                        begin
                            // stray ESC aborts; this byte then follows an ESC
                            step.res.kind = K_ABORT;
                            step.done     = 1'b0;
                            ps_next       = P_ESC;
                            eng_next      = E_SCAN;
                        end
                    end
                    default:
                    begin
                        step.done = 1'b0;
                        ps_next   = P_GROUND;
                        eng_next  = E_SCAN;
                    end
                endcase
            end
            E_REP_ESC:
            begin
                step.emit = 1'b1;
                step.res  = '{kind: K_PASS, data: CH_ESC, seq: '0, ovf: 1'b0};
                eng_next  = E_REP_2ND;
            end
            E_REP_2ND:
            begin
                step.emit = 1'b1;
                step.res  = '{kind: K_PASS, data: second_reg, seq: '0, ovf: 1'b0};
                if (len_reg != '0)
                begin
                    rd_req     = 1'b1;
                    idx_next   = '0;
                    param_next = 1'b0;
                    eng_next   = E_STREAM;
                end
                else
                begin
                    ps_next  = P_GROUND;
                    eng_next = E_SCAN;
                end
            end
            E_STREAM:
            begin
                step.emit     = 1'b1;
                step.res.data = rd_data;
                if (param_reg)
                begin
                    step.res.kind = K_PARAM;
                    step.res.seq  = SEQ_DCS;
                end
                else
                begin
                    step.res.kind = K_PASS;
                end
                if (((LEN_W + 1)'(idx_reg) + 1'b1) < (LEN_W + 1)'(len_reg))
                begin
                    rd_req   = 1'b1;
                    rd_addr  = PFX_AW'(idx_reg + 1'b1);
                    idx_next = idx_reg + 1'b1;
                end
                else if (param_reg)
                begin
                    step.done = 1'b1;
                    eng_next  = E_IDLE;
                end
                else
                begin
                    // replay finished: rescan the byte that broke the introducer
                    ps_next  = P_GROUND;
                    eng_next = E_SCAN;
                end
            end
            default:
            begin
                eng_next = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_reg    <= E_IDLE;
            ps_reg     <= P_GROUND;
            seq_reg    <= SEQ_APC;
            len_reg    <= '0;
            idx_reg    <= '0;
            mask_reg   <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            param_reg  <= 1'b0;
            second_reg <= '0;
            max_reg    <= CAP_RESET;
        end
        else
        begin
            if (advance)
            begin
                eng_reg    <= eng_next;
                ps_reg     <= ps_next;
                seq_reg    <= seq_next;
                len_reg    <= len_next;
                idx_reg    <= idx_next;
                mask_reg   <= mask_next;
                count_reg  <= count_next;
                ovf_reg    <= ovf_next;
                param_reg  <= param_next;
                second_reg <= second_next;
            end
            if (cfg_wr_en)
            begin
                max_reg <= cfg_wr_data;
            end
        end
    end

    // Hold the accepted byte for rescans
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            c_reg <= in_byte;
        end
    end

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(PREFIX_MAX))
        else $error("prefix length beyond RAM depth");

    a_ovf_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (ps_reg == P_BODY) || (ps_reg == P_BODY_ESC))
        else $error("overflow flag set outside a body");

    a_stream_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (eng_reg == E_STREAM) |-> (len_reg != '0) && (idx_reg < len_reg))
        else $error("prefix stream index out of range");

    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !hold)
        else $error("pending result left over when a new item is taken");

endmodule
